@@ design/swst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swst_pkg
// Shared widths, constants, controller states and command/status bundles
// for the sample window statistics block.
// ----------------------------------------------------------------------------
package swst_pkg;

    // field widths
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;
    localparam int SUM_BITS    = 28;
    localparam int STEP_BITS   = 12;
    localparam int MAG_BITS    = STEP_BITS - 1;

    // the window sum stays below count * 2^SAMPLE_BITS, so the quotient
    // fits in SAMPLE_BITS and the partial remainder starts at the upper bits
    localparam int REM_BITS    = SUM_BITS - SAMPLE_BITS;
    localparam int ITER_BITS   = $clog2(SAMPLE_BITS);

    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE   = {SAMPLE_BITS{1'b1}};
    localparam logic [MAG_BITS-1:0]    STEP_MAG_MAX = 11'h7FF;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0]    SUM_MAX      = {SUM_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0]  WINDOW_RESET = 16'd120;
    localparam logic [ITER_BITS-1:0]   ITER_LAST    = ITER_BITS'(SAMPLE_BITS - 1);

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    // controller commands
    typedef struct packed {
        logic accumulate;   // fold the accepted sample into the window
        logic close;        // last sample of a window: snapshot, clear, divide
        logic load_out;     // move the finished result into the output register
    } ctrl_cmd_t;

    // datapath status
    typedef struct packed {
        logic close_due;    // the next sample completes the window
    } dp_sts_t;

    // divider status
    typedef struct packed {
        logic last;         // final quotient bit is produced this cycle
    } div_sts_t;

endpackage

@@ design/swst_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swst_div
// Restoring divider for the window average, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swst_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  swst_pkg::ctrl_cmd_t              cmd,
    input  logic [swst_pkg::SUM_BITS-1:0]    dividend,
    input  logic [swst_pkg::COUNT_BITS-1:0]  divisor,
    output swst_pkg::div_sts_t               sts,
    output logic [swst_pkg::SAMPLE_BITS-1:0] quotient
);
    import swst_pkg::*;

    logic                   busy_reg, busy_next;
    logic [ITER_BITS-1:0]   iter_reg, iter_next;
    logic [REM_BITS-1:0]    rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [COUNT_BITS-1:0]  den_reg, den_next;

    logic [REM_BITS:0]      trial;
    logic [REM_BITS:0]      diff;
    logic                   fits;
    logic                   last;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, quo_reg[SAMPLE_BITS-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
        last  = busy_reg && (iter_reg == ITER_LAST);
    end

    // next values
    always_comb
    begin
        busy_next = busy_reg;
        iter_next = iter_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (cmd.close)
        begin
            busy_next = 1'b1;
            iter_next = '0;
            rem_next  = dividend[SUM_BITS-1:SAMPLE_BITS];
            quo_next  = dividend[SAMPLE_BITS-1:0];
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
            quo_next  = {quo_reg[SAMPLE_BITS-2:0], fits};
            iter_next = iter_reg + 1'b1;
            if (last)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            iter_reg <= iter_next;
        end
    end

    // operand registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign sts.last = last;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    // the quotient must fit the short iteration count
    a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |-> (dividend[SUM_BITS-1:SAMPLE_BITS] < divisor))
        else $error("window sum too large for divider");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");
`endif

endmodule

@@ design/swst_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swst_dp
// Window statistics datapath: running sum, count, min, max, largest step,
// window length register, result snapshot and output register.
// ----------------------------------------------------------------------------
module swst_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swst_pkg::COUNT_BITS-1:0]  cfg_wdata,
    input  logic [swst_pkg::SAMPLE_BITS-1:0] sample,
    input  swst_pkg::ctrl_cmd_t              cmd,
    input  logic [swst_pkg::SAMPLE_BITS-1:0] quotient,
    output swst_pkg::dp_sts_t                sts,
    output logic [swst_pkg::SUM_BITS-1:0]    div_dividend,
    output logic [swst_pkg::COUNT_BITS-1:0]  div_divisor,
    output logic [swst_pkg::SAMPLE_BITS-1:0] average,
    output logic [swst_pkg::SAMPLE_BITS-1:0] minimum,
    output logic [swst_pkg::SAMPLE_BITS-1:0] maximum,
    output logic [swst_pkg::STEP_BITS-1:0]   largest_step,
    output logic [swst_pkg::COUNT_BITS-1:0]  sample_total
);
    import swst_pkg::*;

    logic [COUNT_BITS-1:0]  wlen_reg;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic [SAMPLE_BITS-1:0] prev_reg;
    logic [SAMPLE_BITS-1:0] min_reg, min_next;
    logic [SAMPLE_BITS-1:0] max_reg, max_next;
    logic [STEP_BITS-1:0]   step_reg, step_next;

    logic [SAMPLE_BITS-1:0] snap_min_reg;
    logic [SAMPLE_BITS-1:0] snap_max_reg;
    logic [STEP_BITS-1:0]   snap_step_reg;
    logic [COUNT_BITS-1:0]  snap_total_reg;

    logic [SAMPLE_BITS-1:0] avg_out_reg;
    logic [SAMPLE_BITS-1:0] min_out_reg;
    logic [SAMPLE_BITS-1:0] max_out_reg;
    logic [STEP_BITS-1:0]   step_out_reg;
    logic [COUNT_BITS-1:0]  total_out_reg;

    logic [SUM_BITS:0]      sum_wide;
    logic                   fall;
    logic [SAMPLE_BITS-1:0] mag_full;
    logic [MAG_BITS-1:0]    mag;

    // saturating sum and count
    always_comb
    begin
        sum_wide = {1'b0, sum_reg} + {{(SUM_BITS-SAMPLE_BITS+1){1'b0}}, sample};
        sum_next = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    end

    // min and max
    always_comb
    begin
        min_next = (sample < min_reg) ? sample : min_reg;
        max_next = (sample > max_reg) ? sample : max_reg;
    end

    // step against the previous sample, magnitude saturated
    always_comb
    begin
        fall     = (sample < prev_reg);
        mag_full = fall ? (prev_reg - sample) : (sample - prev_reg);
        mag      = (mag_full > {1'b0, STEP_MAG_MAX}) ? STEP_MAG_MAX
                                                      : mag_full[MAG_BITS-1:0];
        step_next = step_reg;
        if ((count_reg != '0) && (mag > step_reg[MAG_BITS-1:0]))
        begin
            step_next = {fall, mag};
        end
    end

    // window length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlen_reg <= WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            wlen_reg <= cfg_wdata;
        end
    end

    // running statistics, cleared at window end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            prev_reg  <= '0;
            min_reg   <= FULL_SCALE;
            max_reg   <= '0;
            step_reg  <= '0;
        end
        else if (cmd.close)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            prev_reg  <= '0;
            min_reg   <= FULL_SCALE;
            max_reg   <= '0;
            step_reg  <= '0;
        end
        else if (cmd.accumulate)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            prev_reg  <= sample;
            min_reg   <= min_next;
            max_reg   <= max_next;
            step_reg  <= step_next;
        end
    end

    // snapshot of the finished window while the average is divided
    always_ff @(posedge clk)
    begin
        if (cmd.close)
        begin
            snap_min_reg   <= min_next;
            snap_max_reg   <= max_next;
            snap_step_reg  <= step_next;
            snap_total_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            avg_out_reg   <= quotient;
            min_out_reg   <= snap_min_reg;
            max_out_reg   <= snap_max_reg;
            step_out_reg  <= snap_step_reg;
            total_out_reg <= snap_total_reg;
        end
    end

    assign sts.close_due = (count_next >= wlen_reg);
    assign div_dividend  = sum_next;
    assign div_divisor   = count_next;
    assign average       = avg_out_reg;
    assign minimum       = min_out_reg;
    assign maximum       = max_out_reg;
    assign largest_step  = step_out_reg;
    assign sample_total  = total_out_reg;

`ifndef SYNTHESIS
    // a window that holds samples has min not above max
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("window minimum above maximum");
`endif

endmodule

@@ design/swst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swst_ctrl
// Controller: accepts sample beats, starts the window-end division and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module swst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  swst_pkg::dp_sts_t   dp_sts,
    input  swst_pkg::div_sts_t  div_sts,
    output swst_pkg::ctrl_cmd_t cmd
);
    import swst_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && dp_sts.close_due)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_sts.last)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and commands
    always_comb
    begin
        in_stall       = (state_reg != ST_IDLE);
        accept         = in_valid && (state_reg == ST_IDLE);
        cmd.accumulate = accept && !dp_sts.close_due;
        cmd.close      = accept && dp_sts.close_due;
        cmd.load_out   = (state_reg == ST_DELIVER) && out_free;
    end

    // output beat flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while stalled");

    // the divider finishes only while the controller waits for it
    a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.last |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside divide state");

    // a window close always leads into the division
    a_close_divide: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.close |=> (state_reg == ST_DIVIDE))
        else $error("window close did not start division");
`endif

endmodule

@@ design/sample_window_statistics_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_window_statistics_top
// Windowed sum / min / max / largest-step tracker with a floor average
// emitted once per window of window_length samples.
// ----------------------------------------------------------------------------
// A sample beat that does not close a window is accepted without a stall, and
// the next sample can be taken in the following cycle. The sample that closes
// a window starts a restoring divide of the window sum by the count, one
// quotient bit per cycle, followed by the load of the output register; in_stall
// stays high through the divide and the load (more if a previous result is
// still held by out_stall). Results sit in an output register, so sampling
// continues while a finished result waits. A window_length of 0 behaves as 1.
// Write window_length only while idle.
module sample_window_statistics_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swst_pkg::COUNT_BITS-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [swst_pkg::SAMPLE_BITS-1:0] sample,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [swst_pkg::SAMPLE_BITS-1:0] average,
    output logic [swst_pkg::SAMPLE_BITS-1:0] minimum,
    output logic [swst_pkg::SAMPLE_BITS-1:0] maximum,
    output logic [swst_pkg::STEP_BITS-1:0]   largest_step,
    output logic [swst_pkg::COUNT_BITS-1:0]  sample_total
);
    import swst_pkg::*;

    ctrl_cmd_t              cmd;
    dp_sts_t                dp_sts;
    div_sts_t               div_sts;
    logic [SUM_BITS-1:0]    div_dividend;
    logic [COUNT_BITS-1:0]  div_divisor;
    logic [SAMPLE_BITS-1:0] quotient;

    // controller
    swst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_sts    (dp_sts),
        .div_sts   (div_sts),
        .cmd       (cmd)
    );

    // statistics datapath
    swst_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .sample       (sample),
        .cmd          (cmd),
        .quotient     (quotient),
        .sts          (dp_sts),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .average      (average),
        .minimum      (minimum),
        .maximum      (maximum),
        .largest_step (largest_step),
        .sample_total (sample_total)
    );

    // average divider
    swst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (quotient)
    );

endmodule
